// File: hw/rtl/smb_pkg.sv
// Shared constants, codes, types and helpers for the sectored memory bus.
// No dependencies; every other file of the block refers to it by scoped name.
package smb_pkg;

    // Default geometry
    localparam int SECTORS_DEF   = 4;
    localparam int MEM_BYTES_DEF = 65536;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 17;  // sector size, up to 65536
    localparam int BASE_W    = 19;  // packed base, sum of up to four sizes
    localparam int PHYS_W    = 21;  // store offset plus access length
    localparam int CFG_IDX_W = 3;
    localparam int ASIZE_W   = 2;
    localparam int STATUS_W  = 2;
    localparam int LANES     = 4;

    // Access direction
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Access size codes
    localparam logic [ASIZE_W-1:0] SZ_BYTE = 2'd0;
    localparam logic [ASIZE_W-1:0] SZ_HALF = 2'd1;
    localparam logic [ASIZE_W-1:0] SZ_WORD = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CROSS    = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take the accepted request word
        logic clear;     // zero one row of every lane
        logic decode;    // pick the sector
        logic check;     // sector end test, offset
        logic bound;     // tail and store bound tests, physical offset
        logic access;    // drive the byte lanes
        logic form;      // assemble the response word
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
    } t_sts;

    // Bytes moved by an access; the reserved code counts as a word
    function automatic logic [2:0] nbytes(input logic [ASIZE_W-1:0] code);
        logic [2:0] n;
        case (code)
            SZ_BYTE: n = 3'd1;
            SZ_HALF: n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

// File: hw/rtl/smb_if.sv
// Valid/ready channel interfaces of the sectored memory bus.
// Depends on smb_pkg for field widths.
interface smb_req_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [smb_pkg::ASIZE_W-1:0]       access_size;
    logic [smb_pkg::ADDR_W-1:0]        bus_address;
    logic [smb_pkg::DATA_W-1:0]        write_data;

    modport source (output valid, action, access_size, bus_address, write_data,
                    input ready);
    modport sink   (input valid, action, access_size, bus_address, write_data,
                    output ready);
endinterface

interface smb_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [smb_pkg::DATA_W-1:0]        read_data;
    logic [smb_pkg::STATUS_W-1:0]      status;

    modport source (output valid, read_data, status, input ready);
    modport sink   (input valid, read_data, status, output ready);
endinterface

interface smb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [smb_pkg::CFG_IDX_W-1:0]     index;
    logic [smb_pkg::DATA_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/smb_datapath.sv
// Datapath of the sectored memory bus: sector registers, decode and bound
// checks, four byte-lane memories and response assembly. Uses smb_pkg.
module smb_datapath #(
    parameter int SECTORS   = smb_pkg::SECTORS_DEF,
    parameter int MEM_BYTES = smb_pkg::MEM_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smb_pkg::t_cmd                     i_cmd,
    output smb_pkg::t_sts                     o_sts,
    input  logic                              i_action,
    input  logic [smb_pkg::ASIZE_W-1:0]       i_access_size,
    input  logic [smb_pkg::ADDR_W-1:0]        i_bus_address,
    input  logic [smb_pkg::DATA_W-1:0]        i_write_data,
    input  logic                              i_cfg_we,
    input  logic [smb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smb_pkg::DATA_W-1:0]        i_cfg_data,
    output logic [smb_pkg::DATA_W-1:0]        o_read_data,
    output logic [smb_pkg::STATUS_W-1:0]      o_status
);

    localparam int ROWS  = (MEM_BYTES + 3) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Sector registers
    logic [smb_pkg::ADDR_W-1:0] r_start [SECTORS];
    logic [smb_pkg::SIZE_W-1:0] r_size  [SECTORS];

    // Request word
    logic                         r_action;
    logic [smb_pkg::ASIZE_W-1:0]  r_asize;
    logic [smb_pkg::ADDR_W-1:0]   r_addr;
    logic [smb_pkg::DATA_W-1:0]   r_wdata;

    // Decode results
    logic                         r_found, n_found;
    logic [smb_pkg::ADDR_W-1:0]   r_sel_start, n_sel_start;
    logic [smb_pkg::SIZE_W-1:0]   r_sel_size, n_sel_size;
    logic [smb_pkg::BASE_W-1:0]   r_sel_base, n_sel_base;

    // Check results
    logic                         r_unmapped, n_unmapped;
    logic [smb_pkg::SIZE_W-1:0]   r_off, n_off;

    // Bound results
    logic                         r_fault, n_fault;
    logic [smb_pkg::STATUS_W-1:0] r_status, n_status;
    logic [smb_pkg::PHYS_W-1:0]   r_phys, n_phys;

    // Lanes and response
    logic [ROW_W-1:0]             r_clr_row;
    logic [7:0]                   r_lane_q [smb_pkg::LANES];
    logic [smb_pkg::DATA_W-1:0]   r_rdata, n_rdata;
    logic [smb_pkg::STATUS_W-1:0] r_rstat;

    logic [2:0]                   w_n;
    logic [1:0]                   w_lo;
    logic [ROW_W-1:0]             w_row0;

    assign w_n    = smb_pkg::nbytes(r_asize);
    assign w_lo   = r_phys[1:0];
    assign w_row0 = r_phys[ROW_W+1:2];

    // Write sector registers; indexes past the sector count are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SECTORS; i++) begin
                r_start[i] <= '0;
                r_size[i]  <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < SECTORS; i++) begin
                if (i_cfg_index[2:1] == 2'(i)) begin
                    if (i_cfg_index[0]) begin
                        r_size[i] <= i_cfg_data[smb_pkg::SIZE_W-1:0];
                    end else begin
                        r_start[i] <= i_cfg_data;
                    end
                end
            end
        end
    end

    // Hold the accepted request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_asize  <= i_access_size;
            r_addr   <= i_bus_address;
            r_wdata  <= i_write_data;
        end
    end

    // Pick the last sector starting at or below the address
    always_comb begin
        logic [smb_pkg::BASE_W-1:0] base;
        base        = '0;
        n_found     = 1'b0;
        n_sel_start = '0;
        n_sel_size  = '0;
        n_sel_base  = '0;
        for (int i = 0; i < SECTORS; i++) begin
            if (r_start[i] <= r_addr) begin
                n_found     = 1'b1;
                n_sel_start = r_start[i];
                n_sel_size  = r_size[i];
                n_sel_base  = base;
            end
            base = base + smb_pkg::BASE_W'(r_size[i]);
        end
    end

    // Test against the sector end and take the offset
    always_comb begin
        logic [smb_pkg::ADDR_W:0] sec_end;
        sec_end    = {1'b0, r_sel_start} + (smb_pkg::ADDR_W+1)'(r_sel_size);
        n_unmapped = !r_found || ({1'b0, r_addr} >= sec_end);
        n_off      = smb_pkg::SIZE_W'(r_addr - r_sel_start);
    end

    // Tail and store bound tests, physical offset
    always_comb begin
        logic                      tail;
        logic                      outside;
        logic [smb_pkg::SIZE_W:0]  last;
        last    = {1'b0, r_off} + (smb_pkg::SIZE_W+1)'(w_n);
        tail    = last > {1'b0, r_sel_size};
        n_phys  = smb_pkg::PHYS_W'(r_sel_base) + smb_pkg::PHYS_W'(r_off);
        outside = (n_phys + smb_pkg::PHYS_W'(w_n)) > smb_pkg::PHYS_W'(MEM_BYTES);
        if (r_unmapped) begin
            n_status = smb_pkg::ST_UNMAPPED;
        end else if (tail) begin
            n_status = smb_pkg::ST_CROSS;
        end else if (outside) begin
            n_status = smb_pkg::ST_UNMAPPED;
        end else begin
            n_status = smb_pkg::ST_OK;
        end
        n_fault = r_unmapped || tail || outside;
    end

    // Advance the decode, check and bound registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_found     <= n_found;
            r_sel_start <= n_sel_start;
            r_sel_size  <= n_sel_size;
            r_sel_base  <= n_sel_base;
        end
        if (i_cmd.check) begin
            r_unmapped <= n_unmapped;
            r_off      <= n_off;
        end
        if (i_cmd.bound) begin
            r_fault  <= n_fault;
            r_status <= n_status;
            r_phys   <= n_phys;
        end
    end

    // Step through the rows while the store is being cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clear) begin
            r_clr_row <= r_clr_row + 1'b1;
        end
    end

    assign o_sts.clear_last = (r_clr_row == ROW_W'(ROWS - 1));

    // Byte lanes: byte p of the store sits in lane p mod 4, row p / 4
    for (genvar g = 0; g < smb_pkg::LANES; g++) begin : g_lane
        logic [7:0]       mem [ROWS];
        logic [1:0]       k;
        logic             used;
        logic             we;
        logic [ROW_W-1:0] row;
        logic [7:0]       wd;

        always_comb begin
            k    = 2'(g) - w_lo;
            used = {1'b0, k} < w_n;
            if (i_cmd.clear) begin
                we  = 1'b1;
                row = r_clr_row;
                wd  = '0;
            end else begin
                we  = i_cmd.access && used && !r_fault && (r_action == smb_pkg::ACT_WRITE);
                row = (2'(g) >= w_lo) ? w_row0 : w_row0 + 1'b1;
                wd  = r_wdata[8*k +: 8];
            end
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[row] <= wd;
            end
            if (i_cmd.access) begin
                r_lane_q[g] <= mem[row];
            end
        end
    end

    // Assemble the little-endian read word, zero on writes and faults
    always_comb begin
        logic [1:0] lane;
        n_rdata = '0;
        for (int k = 0; k < smb_pkg::LANES; k++) begin
            lane = w_lo + 2'(k);
            if (3'(k) < w_n) begin
                n_rdata[8*k +: 8] = r_lane_q[lane];
            end
        end
        if (r_fault || (r_action == smb_pkg::ACT_WRITE)) begin
            n_rdata = '0;
        end
    end

    // Hold the response word
    always_ff @(posedge i_clk) begin
        if (i_cmd.form) begin
            r_rdata <= n_rdata;
            r_rstat <= r_status;
        end
    end

    assign o_read_data = r_rdata;
    assign o_status    = r_rstat;

endmodule

// File: hw/rtl/smb_ctrl.sv
// Controller of the sectored memory bus: clearing pass, then one request word
// at a time through decode, check, bound, access and response. Uses smb_pkg.
module smb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    input  smb_pkg::t_sts i_sts,
    output smb_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_CHECK  = 8'b0000_1000,
        S_BOUND  = 8'b0001_0000,
        S_ACCESS = 8'b0010_0000,
        S_FORM   = 8'b0100_0000,
        S_REPLY  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Advance the sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (i_sts.clear_last) n_state = S_IDLE;
            S_IDLE:   if (i_req_valid) n_state = S_DECODE;
            S_DECODE: n_state = S_CHECK;
            S_CHECK:  n_state = S_BOUND;
            S_BOUND:  n_state = S_ACCESS;
            S_ACCESS: n_state = S_FORM;
            S_FORM:   n_state = S_REPLY;
            S_REPLY:  if (i_rsp_ready) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive handshakes and datapath commands
    assign o_req_ready   = (r_state == S_IDLE);
    assign o_rsp_valid   = (r_state == S_REPLY);
    assign o_cmd.capture = (r_state == S_IDLE) && i_req_valid;
    assign o_cmd.clear   = (r_state == S_CLEAR);
    assign o_cmd.decode  = (r_state == S_DECODE);
    assign o_cmd.check   = (r_state == S_CHECK);
    assign o_cmd.bound   = (r_state == S_BOUND);
    assign o_cmd.access  = (r_state == S_ACCESS);
    assign o_cmd.form    = (r_state == S_FORM);

endmodule

// File: hw/rtl/sectored_memory_bus.sv
// Sectored memory bus: one request word in, one response word out.
// The response is valid after the request has passed the decode, check, bound,
// access and form states. The single-word sequencer takes no new request until
// the last response is taken. Reset clears the sector registers and runs a
// clearing pass over the store's rows (16384 by default), one row of four bytes
// a cycle; requests are held off until it ends, configuration writes are taken.
module sectored_memory_bus #(
    parameter int SECTORS   = smb_pkg::SECTORS_DEF,
    parameter int MEM_BYTES = smb_pkg::MEM_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    smb_req_if.sink   i_req,
    smb_rsp_if.source o_rsp,
    smb_cfg_if.sink   i_cfg
);

    smb_pkg::t_cmd w_cmd;
    smb_pkg::t_sts w_sts;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    smb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    smb_datapath #(
        .SECTORS   (SECTORS),
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_action      (i_req.action),
        .i_access_size (i_req.access_size),
        .i_bus_address (i_req.bus_address),
        .i_write_data  (i_req.write_data),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_read_data   (o_rsp.read_data),
        .o_status      (o_rsp.status)
    );

endmodule
